// File: hw/rtl/sipf_pkg.sv
`default_nettype none

package sipf_pkg;

	// input modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_PARAM = 2'd1;
	localparam logic [1:0] MODE_PING  = 2'd2;
	localparam logic [1:0] MODE_RSVD  = 2'd3;

	// packet bytes
	localparam logic [7:0]  HDR_A     = 8'hFF;
	localparam logic [7:0]  HDR_B     = 8'hFD;
	localparam logic [7:0]  HDR_RSV   = 8'h00;
	localparam logic [7:0]  LEN_HI    = 8'h00;
	localparam logic [7:0]  LEN_EXTRA = 8'h03;
	localparam logic [7:0]  OP_WRITE  = 8'h03;
	localparam logic [7:0]  OP_PING   = 8'h01;
	localparam logic [15:0] CRC_POLY  = 16'h8005;

	// byte positions inside a packet as walked by the back end
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_HDR0  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_HDR1  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_HDR2  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_RSV   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_ID    = 4'd4;
	localparam logic [STEP_W-1:0] STEP_LENL  = 4'd5;
	localparam logic [STEP_W-1:0] STEP_LENH  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_OP    = 4'd7;
	localparam logic [STEP_W-1:0] STEP_CRC_L = 4'd8;
	localparam logic [STEP_W-1:0] STEP_CRC_H = 4'd9;

	// command queue geometry
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] param_count;
		logic [7:0] data_byte;
	} sipf_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
	} sipf_out_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_PARAM = 2'd1,
		CMD_PING  = 2'd2
	} cmd_kind_t;

	// classified command handed from front to back
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] cnt;
		logic [7:0] data;
		logic       last;
	} cmd_t;

	// CRC-16, poly 0x8005, MSB first, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sipf_front.sv
`default_nettype none

module sipf_front #(
	parameter int MAX_PARAMS = 252
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  sipf_pkg::sipf_in_t in_req,
	output logic             push,
	output sipf_pkg::cmd_t   push_cmd,
	input  wire              q_full
);

	localparam logic [7:0] MaxCnt = 8'(MAX_PARAMS);

	logic       open_q;
	logic [7:0] left_q;
	logic       open_d;
	logic [7:0] left_d;
	logic       take;
	logic [7:0] cnt_sat;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;
	assign cnt_sat  = (in_req.param_count > MaxCnt) ? MaxCnt : in_req.param_count;

	// classify the request and track the open packet
	always_comb begin
		push          = 1'b0;
		push_cmd.kind = sipf_pkg::CMD_WRITE;
		push_cmd.cnt  = cnt_sat;
		push_cmd.data = in_req.data_byte;
		push_cmd.last = (left_q == 8'd1);
		open_d        = open_q;
		left_d        = left_q;
		if (take) begin
			unique case (in_req.mode)
				sipf_pkg::MODE_WRITE: begin
					push          = 1'b1;
					push_cmd.kind = sipf_pkg::CMD_WRITE;
					open_d        = (cnt_sat != 8'd0);
					left_d        = cnt_sat;
				end
				sipf_pkg::MODE_PARAM: begin
					// stray bytes with no packet open are dropped
					if (open_q && left_q != 8'd0) begin
						push          = 1'b1;
						push_cmd.kind = sipf_pkg::CMD_PARAM;
						left_d        = left_q - 8'd1;
						open_d        = (left_q != 8'd1);
					end
				end
				sipf_pkg::MODE_PING: begin
					push          = 1'b1;
					push_cmd.kind = sipf_pkg::CMD_PING;
					open_d        = 1'b0;
					left_d        = 8'd0;
				end
				sipf_pkg::MODE_RSVD: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			left_q <= 8'd0;
		end else begin
			open_q <= open_d;
			left_q <= left_d;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sipf_cmdq.sv
`default_nettype none

module sipf_cmdq (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  sipf_pkg::cmd_t  push_cmd,
	output logic            full,
	input  wire             pop,
	output logic            head_valid,
	output sipf_pkg::cmd_t  head_cmd
);

	localparam int AW = sipf_pkg::CMDQ_AW;
	localparam logic [AW:0] Depth = (AW + 1)'(sipf_pkg::CMDQ_DEPTH);

	sipf_pkg::cmd_t mem_q [sipf_pkg::CMDQ_DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [AW:0]    cnt_q;
	logic           do_pop;

	assign full       = (cnt_q == Depth);
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rptr_q];
	assign do_pop     = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push && !full) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({push && !full, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/sipf_back.sv
`default_nettype none

module sipf_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [7:0]        servo_id,
	input  wire               cmd_valid,
	input  sipf_pkg::cmd_t    cmd,
	output logic              pop,
	output logic              out_valid,
	input  wire               out_stall,
	output sipf_pkg::sipf_out_t out_req
);

	localparam int SW = sipf_pkg::STEP_W;

	logic [SW-1:0]       step_q;
	logic [SW-1:0]       step_d;
	logic [15:0]         crc_q;
	logic                out_valid_q;
	sipf_pkg::sipf_out_t out_req_q;
	logic                advance;
	logic                is_hdr;
	logic                last_step;
	logic [7:0]          byte_d;
	logic [15:0]         crc_base;

	assign is_hdr  = (cmd.kind != sipf_pkg::CMD_PARAM);
	assign advance = cmd_valid && (!out_valid_q || !out_stall);

	// byte for the current position
	always_comb begin
		unique case (step_q)
			sipf_pkg::STEP_HDR0:  byte_d = is_hdr ? sipf_pkg::HDR_A : cmd.data;
			sipf_pkg::STEP_HDR1:  byte_d = sipf_pkg::HDR_A;
			sipf_pkg::STEP_HDR2:  byte_d = sipf_pkg::HDR_B;
			sipf_pkg::STEP_RSV:   byte_d = sipf_pkg::HDR_RSV;
			sipf_pkg::STEP_ID:    byte_d = servo_id;
			sipf_pkg::STEP_LENL:  byte_d = (cmd.kind == sipf_pkg::CMD_WRITE) ?
				8'(cmd.cnt + sipf_pkg::LEN_EXTRA) : sipf_pkg::LEN_EXTRA;
			sipf_pkg::STEP_LENH:  byte_d = sipf_pkg::LEN_HI;
			sipf_pkg::STEP_OP:    byte_d = (cmd.kind == sipf_pkg::CMD_WRITE) ?
				sipf_pkg::OP_WRITE : sipf_pkg::OP_PING;
			sipf_pkg::STEP_CRC_L: byte_d = crc_q[7:0];
			sipf_pkg::STEP_CRC_H: byte_d = crc_q[15:8];
			default:              byte_d = 8'h00;
		endcase
	end

	// sequencing through the command's bytes
	always_comb begin
		last_step = 1'b0;
		step_d    = step_q + 1'b1;
		priority if (step_q == sipf_pkg::STEP_CRC_H) begin
			last_step = 1'b1;
		end else if (!is_hdr && step_q == sipf_pkg::STEP_HDR0) begin
			last_step = !cmd.last;
			step_d    = sipf_pkg::STEP_CRC_L;
		end else if (cmd.kind == sipf_pkg::CMD_WRITE && step_q == sipf_pkg::STEP_OP) begin
			last_step = (cmd.cnt != 8'd0);
		end else begin
			last_step = 1'b0;
		end
		if (last_step) begin
			step_d = sipf_pkg::STEP_HDR0;
		end
	end

	assign pop      = advance && last_step;
	// a header restarts the checksum
	assign crc_base = (is_hdr && step_q == sipf_pkg::STEP_HDR0) ? 16'h0000 : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= sipf_pkg::STEP_HDR0;
			crc_q       <= 16'h0000;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= step_d;
				out_valid_q <= 1'b1;
				if (step_q < sipf_pkg::STEP_CRC_L) begin
					crc_q <= sipf_pkg::crc_byte(crc_base, byte_d);
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_req_q.out_byte   <= byte_d;
			out_req_q.packet_end <= (step_q == sipf_pkg::STEP_CRC_H);
		end
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_req_q;

	// position never runs past the CRC high byte
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= sipf_pkg::STEP_CRC_H)
		else $error("back end step out of range");

	// a command in progress stays at the queue head
	a_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != sipf_pkg::STEP_HDR0 |-> cmd_valid)
		else $error("command left queue mid packet");

	// parameter commands never walk header positions
	a_param_no_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd.kind == sipf_pkg::CMD_PARAM) |->
		(step_q == sipf_pkg::STEP_HDR0 || step_q == sipf_pkg::STEP_CRC_L ||
		 step_q == sipf_pkg::STEP_CRC_H))
		else $error("parameter command at header position");

	// the end flag goes out only with a checksum high byte
	a_end_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_q == sipf_pkg::STEP_CRC_H) |=> out_req_q.packet_end)
		else $error("packet end flag missing");

endmodule

`default_nettype wire

// File: hw/rtl/servo_instruction_packet_framer.sv
`default_nettype none

// Servo instruction packet framer: turns requests into the byte stream of
// protocol 2.0 instruction packets with a CRC-16 (poly 0x8005) trailer.
// Input channel (in_valid / in_stall / in_req): a begin-write request emits
// the 8-byte header, each parameter request emits its byte, and the last
// parameter adds CRC low and high bytes; a ping request emits a full
// 10-byte ping. Stray parameter requests and mode three produce nothing.
// Output channel (out_valid / out_stall / out_req): one wire byte per
// transfer, packet_end set on the CRC high byte.
// cfg_we / cfg_wdata write the servo id used in every header.
// Accepted requests go through the queue, then the back end's output register.
// The back end sends one byte per cycle from its output register while
// out_stall is low; a parameter request yields one byte (three for the last),
// a begin write 8 bytes (10 with zero count) and a ping 10 bytes.
// A four-entry command queue sits between classification and byte
// generation; the input stalls only when that queue is full.
// Reset: servo id 1, no packet open, queue and output register empty.
// While out_stall is high the held byte stays put and the back end pauses;
// the front keeps taking requests until the queue fills.
module servo_instruction_packet_framer #(
	parameter int MAX_PARAMS = 252
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  sipf_pkg::sipf_in_t  in_req,
	output logic                out_valid,
	input  wire                 out_stall,
	output sipf_pkg::sipf_out_t out_req,
	input  wire                 cfg_we,
	input  wire  [7:0]          cfg_wdata
);

	logic [7:0]     servo_id_q;
	logic           push;
	sipf_pkg::cmd_t push_cmd;
	logic           q_full;
	logic           pop;
	logic           head_valid;
	sipf_pkg::cmd_t head_cmd;

	// servo id register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_id_q <= 8'd1;
		end else if (cfg_we) begin
			servo_id_q <= cfg_wdata;
		end
	end

	sipf_front #(
		.MAX_PARAMS(MAX_PARAMS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_req   (in_req),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	sipf_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	sipf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.servo_id  (servo_id_q),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_req   (out_req)
	);

	// config is only written while idle: no request in the queue or output
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> (!head_valid && !out_valid))
		else $error("servo id written while requests in flight");

endmodule

`default_nettype wire

// File: dv/tb_servo_instruction_packet_framer.sv
`timescale 1ns / 100ps

module tb_servo_instruction_packet_framer;

	localparam int MAX_PARAMS     = 252;
	localparam int DRAIN_CYCLES   = 16;
	localparam int HOLD_CYCLES    = 120;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	sipf_pkg::sipf_in_t  in_req = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	sipf_pkg::sipf_out_t out_req;
	logic                cfg_we = 1'b0;
	logic [7:0]          cfg_wdata = 8'h00;

	// framer shadow state
	logic [7:0]  id_shadow = 8'd1;
	logic [15:0] run_crc = '0;
	logic [7:0]  bytes_owed = '0;
	logic        write_open = 1'b0;

	sipf_pkg::sipf_in_t  pending_reqs[$];
	sipf_pkg::sipf_out_t wire_bytes[$];

	int src_idle_pct = 35;
	int sink_idle_pct = 35;
	logic want_hold = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int n_reqs = 0;
	int n_bytes = 0;
	int n_packets = 0;
	int n_err = 0;

	servo_instruction_packet_framer #(
		.MAX_PARAMS(MAX_PARAMS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_req(out_req),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// CRC-16 0x8005, bit at a time, MSB first
	function automatic logic [15:0] crc16_shift(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ sipf_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic void emit_byte(input logic [7:0] b);
		sipf_pkg::sipf_out_t o;
		o.out_byte   = b;
		o.packet_end = 1'b0;
		wire_bytes.push_back(o);
		run_crc = crc16_shift(run_crc, b);
	endfunction

	// CRC trailer, low byte first; the trailer is not folded into the CRC
	function automatic void emit_crc();
		sipf_pkg::sipf_out_t o;
		o.out_byte   = run_crc[7:0];
		o.packet_end = 1'b0;
		wire_bytes.push_back(o);
		o.out_byte   = run_crc[15:8];
		o.packet_end = 1'b1;
		wire_bytes.push_back(o);
		run_crc = '0;
	endfunction

	function automatic void emit_header(input logic [15:0] len, input logic [7:0] op);
		run_crc = '0;
		emit_byte(sipf_pkg::HDR_A);
		emit_byte(sipf_pkg::HDR_A);
		emit_byte(sipf_pkg::HDR_B);
		emit_byte(sipf_pkg::HDR_RSV);
		emit_byte(id_shadow);
		emit_byte(len[7:0]);
		emit_byte(len[15:8]);
		emit_byte(op);
	endfunction

	// expected wire bytes for one accepted request
	function automatic void frame_request(input sipf_pkg::sipf_in_t r);
		logic [7:0] cnt;
		cnt = (r.param_count > MAX_PARAMS) ? 8'(MAX_PARAMS) : r.param_count;
		case (r.mode)
			sipf_pkg::MODE_WRITE: begin
				emit_header({8'h00, cnt} + {8'h00, sipf_pkg::LEN_EXTRA}, sipf_pkg::OP_WRITE);
				if (cnt == 8'd0) begin
					emit_crc();
					write_open = 1'b0;
					bytes_owed = '0;
				end else begin
					write_open = 1'b1;
					bytes_owed = cnt;
				end
			end
			sipf_pkg::MODE_PARAM: begin
				// stray byte with nothing open is dropped
				if (write_open && bytes_owed != 8'd0) begin
					emit_byte(r.data_byte);
					bytes_owed = bytes_owed - 8'd1;
					if (bytes_owed == 8'd0) begin
						emit_crc();
						write_open = 1'b0;
					end
				end
			end
			sipf_pkg::MODE_PING: begin
				emit_header({8'h00, sipf_pkg::LEN_EXTRA}, sipf_pkg::OP_PING);
				emit_crc();
				write_open = 1'b0;
				bytes_owed = '0;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void push_req(input logic [1:0] m, input logic [7:0] cnt,
			input logic [7:0] dat);
		sipf_pkg::sipf_in_t r;
		r.mode        = m;
		r.param_count = cnt;
		r.data_byte   = dat;
		pending_reqs.push_back(r);
	endfunction

	// request driver: takes the next pending request, idles at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_req   <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				frame_request(in_req);
				n_reqs++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					in_valid <= 1'b1;
					in_req   <= pending_reqs.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// byte monitor and receiver stall generator
	always @(posedge clk or negedge arst_n) begin : byte_monitor
		sipf_pkg::sipf_out_t want;
		logic                hold_now;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (wire_bytes.size() == 0) begin
					$error("unexpected byte: out_byte %02h packet_end %0b",
						out_req.out_byte, out_req.packet_end);
					n_err++;
				end else begin
					want = wire_bytes.pop_front();
					if (out_req.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, got %02h",
							want.out_byte, out_req.out_byte);
						n_err++;
					end
					if (out_req.packet_end !== want.packet_end) begin
						$error("packet_end: expected %0b, got %0b",
							want.packet_end, out_req.packet_end);
						n_err++;
					end
					n_bytes++;
					if (want.packet_end) begin
						n_packets++;
					end
				end
			end
			// one long hold-off on request, otherwise random stalls
			if (hold_left != 0) begin
				hold_now = 1'b1;
				hold_left <= hold_left - 1;
			end else if (want_hold && !hold_done) begin
				hold_now = 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				hold_done <= 1'b1;
			end else begin
				hold_now = ($urandom_range(0, 99) < sink_idle_pct);
			end
			out_stall <= hold_now;
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_servo_instruction_packet_framer failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// wait until every request is taken and every byte is out, then let
	// requests with no bytes clear the pipeline
	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || wire_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_servo_id(input logic [7:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		id_shadow = v;
	endtask

	// mostly well-formed write packets with random content, plus noise
	task automatic queue_random(input int n);
		int target;
		int cnt;
		int stop;
		int sel;
		target = pending_reqs.size() + n;
		while (pending_reqs.size() < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: cnt = $urandom_range(1, 6);
					6, 7, 8: cnt = $urandom_range(7, 24);
					default: cnt = $urandom_range(25, 60);
				endcase
				// now and then the packet is cut short by the next one
				stop = ($urandom_range(0, 15) == 0) ? $urandom_range(0, cnt - 1) : cnt;
				push_req(sipf_pkg::MODE_WRITE, 8'(cnt), 8'($urandom_range(0, 255)));
				for (int i = 0; i < stop; i++) begin
					if ($urandom_range(0, 24) == 0) begin
						push_req(sipf_pkg::MODE_RSVD, 8'($urandom_range(0, 255)),
							8'($urandom_range(0, 255)));
					end
					push_req(sipf_pkg::MODE_PARAM, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end
			end else if (sel < 72) begin
				push_req(sipf_pkg::MODE_PING, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			end else if (sel < 80) begin
				push_req(sipf_pkg::MODE_WRITE, 8'd0, 8'($urandom_range(0, 255)));
			end else if (sel < 88) begin
				push_req(sipf_pkg::MODE_PARAM, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			end else if (sel < 93) begin
				push_req(sipf_pkg::MODE_RSVD, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			end else begin
				// over-range count, left open
				push_req(sipf_pkg::MODE_WRITE, 8'($urandom_range(MAX_PARAMS + 1, 255)),
					8'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 4)) begin
					push_req(sipf_pkg::MODE_PARAM, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	initial begin : stimulus
		logic [7:0] rand_id;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed requests with the reset id
		push_req(sipf_pkg::MODE_PING, 8'hFF, 8'hFF);
		push_req(sipf_pkg::MODE_WRITE, 8'd0, 8'h00);
		push_req(sipf_pkg::MODE_WRITE, 8'd1, 8'hFF);
		push_req(sipf_pkg::MODE_PARAM, 8'h00, 8'h00);
		push_req(sipf_pkg::MODE_WRITE, 8'd2, 8'h00);
		push_req(sipf_pkg::MODE_PARAM, 8'hFF, 8'hFF);
		push_req(sipf_pkg::MODE_PARAM, 8'h00, 8'h5A);
		push_req(sipf_pkg::MODE_PARAM, 8'h00, 8'hA5);
		push_req(sipf_pkg::MODE_RSVD, 8'hFF, 8'hFF);
		// reserved mode inside an open packet, then a ping cuts it off
		push_req(sipf_pkg::MODE_WRITE, 8'd3, 8'h00);
		push_req(sipf_pkg::MODE_PARAM, 8'h55, 8'h12);
		push_req(sipf_pkg::MODE_RSVD, 8'h00, 8'h00);
		push_req(sipf_pkg::MODE_PARAM, 8'hAA, 8'h34);
		push_req(sipf_pkg::MODE_PING, 8'h00, 8'h00);
		// saturated count, then a new write takes over
		push_req(sipf_pkg::MODE_WRITE, 8'hFF, 8'h00);
		push_req(sipf_pkg::MODE_PARAM, 8'h00, 8'h80);
		push_req(sipf_pkg::MODE_WRITE, 8'd1, 8'h00);
		push_req(sipf_pkg::MODE_PARAM, 8'h00, 8'h7F);
		push_req(sipf_pkg::MODE_WRITE, 8'(MAX_PARAMS + 1), 8'hFF);
		push_req(sipf_pkg::MODE_WRITE, 8'd2, 8'hC3);
		push_req(sipf_pkg::MODE_PARAM, 8'h80, 8'h01);
		push_req(sipf_pkg::MODE_PARAM, 8'h7F, 8'hFE);
		push_req(sipf_pkg::MODE_PARAM, 8'h00, 8'h33);
		drain();

		set_servo_id(8'd0);
		queue_random(45);
		drain();

		// no idling on either side, plus one long receiver hold-off
		set_servo_id(8'd253);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		queue_random(60);
		want_hold = 1'b1;
		drain();

		// id outside its range
		set_servo_id(8'hFF);
		src_idle_pct  = 35;
		sink_idle_pct = 35;
		queue_random(40);
		drain();

		rand_id = 8'($urandom_range(0, 253));
		set_servo_id(rand_id);
		queue_random(40);
		drain();

		$display("checked %0d requests, %0d wire bytes, %0d closed packets",
			n_reqs, n_bytes, n_packets);
		$display("servo ids 1, 0, 253, 255 and %0d; receiver hold-off of %0d cycles",
			rand_id, HOLD_CYCLES);
		if (n_err == 0) begin
			$display("tb_servo_instruction_packet_framer passed");
		end else begin
			$display("tb_servo_instruction_packet_framer failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/sipf_pkg.sv
hw/rtl/sipf_front.sv
hw/rtl/sipf_cmdq.sv
hw/rtl/sipf_back.sv
hw/rtl/servo_instruction_packet_framer.sv
dv/tb_servo_instruction_packet_framer.sv
